@@ src/rmv_pkg.sv @@
// Shared types and constants for the running mean and variance block.
// No dependencies; used by running_mean_variance.
`timescale 1ns / 1ps

package rmv_pkg;

   localparam int SAMPLE_BITS        = 16;
   localparam int MEAN_BITS          = 24;
   localparam int VAR_BITS           = 32;
   localparam int COUNT_OUT_BITS     = 24;
   localparam int MAG_BITS           = 24;  // magnitude of x - mean, always below 2^24
   localparam int DIV_BITS           = 32;  // dividend width of the serial divider
   localparam int FRAC_SHIFT         = 16;  // d^2 is Q16.32, variance is Q16.16
   localparam int COUNT_BITS_DEFAULT = 24;
   localparam int CSR_INDEX_BITS     = 2;
   localparam int CSR_DATA_BITS      = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_INIT_MEAN     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INIT_VARIANCE = 2'd1;

   typedef struct packed {
      logic                          mode;
      logic signed [SAMPLE_BITS-1:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [MEAN_BITS-1:0] mean_out;
      logic [VAR_BITS-1:0]         variance_out;
      logic [COUNT_OUT_BITS-1:0]   count_out;
      logic                        variance_saturated;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_MEAN,
      ST_DIV_VAR,
      ST_DIV_SQ,
      ST_FINISH
   } state_type;

endpackage

@@ src/running_mean_variance.sv @@
// A sample word's result is presented after its three divisions and the commit in
// ST_FINISH; a restart word goes straight to ST_FINISH. The commit waits while an
// untaken result holds the output register, and a new word is accepted only after it.
// The sample rate is set by the single bit-serial restoring divider, one quotient bit a
// cycle, run three times per sample; the 24-step shift-add squarer overlaps the
// first division. Reset (synchronous, active high) clears mean, variance and
// registers to zero, sets the count to 1 and drops any pending result.
`timescale 1ns / 1ps

module running_mean_variance #(
   parameter int COUNT_BITS = rmv_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rmv_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rmv_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [rmv_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rmv_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int MB = rmv_pkg::MEAN_BITS;
   localparam int VB = rmv_pkg::VAR_BITS;
   localparam int AB = rmv_pkg::MAG_BITS;
   localparam int DB = rmv_pkg::DIV_BITS;
   localparam int STEP_BITS = $clog2(DB + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Control state
   rmv_pkg::state_type state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Configuration and running statistics
   logic [MB-1:0]         init_mean_ff, init_mean_in;
   logic [VB-1:0]         init_var_ff, init_var_in;
   logic [MB-1:0]         run_mean_ff, run_mean_in;
   logic [VB-1:0]         run_var_ff, run_var_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   // Per-word working registers
   logic [COUNT_BITS-1:0] n_ff, n_in;
   logic                  neg_ff, neg_in;
   logic [AB-1:0]         ad_ff, ad_in;
   logic [AB-1:0]         prod_hi_ff, prod_hi_in;
   logic [AB-1:0]         prod_lo_ff, prod_lo_in;
   logic [COUNT_BITS-1:0] div_rem_ff, div_rem_in;
   logic [DB-1:0]         div_quo_ff, div_quo_in;
   logic [COUNT_BITS-1:0] div_den_ff, div_den_in;
   logic [MB-1:0]         mean_new_ff, mean_new_in;
   logic [VB-1:0]         t1_ff, t1_in;
   logic [VB-1:0]         var_new_ff, var_new_in;
   logic                  sat_new_ff, sat_new_in;

   rmv_pkg::rsp_type rsp_ff, rsp_in;

   // Datapath helpers
   logic [COUNT_BITS:0]   div_shift;
   logic [COUNT_BITS:0]   div_diff;
   logic                  div_ge;
   logic [AB:0]           mul_sum;
   logic [AB:0]           x_ext, m_ext, d_ext, ad_ext;
   logic [COUNT_BITS-1:0] n_next;
   logic [AB:0]           q_signed, mean_sum;
   logic [VB:0]           var_sum;
   logic [rmv_pkg::COUNT_OUT_BITS-1:0] count_trim;
   logic                  accept;
   logic                  commit;

   assign req_ready = (state_ff == rmv_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign accept    = req_valid && req_ready;

   // count_out carries the low bits of the count, zero-extended if it is narrower
   generate
      if (COUNT_BITS >= rmv_pkg::COUNT_OUT_BITS) begin : g_trim
         assign count_trim = n_ff[rmv_pkg::COUNT_OUT_BITS-1:0];
      end else begin : g_extend
         assign count_trim = {{(rmv_pkg::COUNT_OUT_BITS - COUNT_BITS){1'b0}}, n_ff};
      end
   endgenerate

   // One restoring-divide step: shift in the next dividend bit, subtract if it fits
   assign div_shift = {div_rem_ff, div_quo_ff[DB-1]};
   assign div_ge    = div_shift >= {1'b0, div_den_ff};
   assign div_diff  = div_shift - {1'b0, div_den_ff};

   // One shift-add squaring step on |d|
   assign mul_sum = {1'b0, prod_hi_ff} + (prod_lo_ff[0] ? {1'b0, ad_ff} : {(AB + 1){1'b0}});

   // Front end: sample as Q8.16, deviation from the current mean and the new count
   assign x_ext  = {req_data.sample[rmv_pkg::SAMPLE_BITS-1], req_data.sample, 8'b0};
   assign m_ext  = {run_mean_ff[MB-1], run_mean_ff};
   assign d_ext  = x_ext - m_ext;
   assign ad_ext = d_ext[AB] ? ((AB + 1)'(0) - d_ext) : d_ext;
   assign n_next = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + COUNT_BITS'(1);

   // Mean step: quotient of |d| / n with the sign of d, truncating toward zero
   assign q_signed = neg_ff ? ((AB + 1)'(0) - {1'b0, div_quo_ff[AB-1:0]})
                            : {1'b0, div_quo_ff[AB-1:0]};
   assign mean_sum = {run_mean_ff[MB-1], run_mean_ff} + q_signed;

   // Variance sum: first term plus d^2 / n, with carry as the saturation flag
   assign var_sum = {1'b0, t1_ff} + {1'b0, div_quo_ff};

   assign commit = (state_ff == rmv_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmv_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         init_mean_ff <= '0;
         init_var_ff  <= '0;
         run_mean_ff  <= '0;
         run_var_ff   <= '0;
         count_ff     <= COUNT_BITS'(1);
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         init_mean_ff <= init_mean_in;
         init_var_ff  <= init_var_in;
         run_mean_ff  <= run_mean_in;
         run_var_ff   <= run_var_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      neg_ff      <= neg_in;
      ad_ff       <= ad_in;
      prod_hi_ff  <= prod_hi_in;
      prod_lo_ff  <= prod_lo_in;
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_den_ff  <= div_den_in;
      mean_new_ff <= mean_new_in;
      t1_ff       <= t1_in;
      var_new_ff  <= var_new_in;
      sat_new_ff  <= sat_new_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      init_mean_in = init_mean_ff;
      init_var_in  = init_var_ff;
      run_mean_in  = run_mean_ff;
      run_var_in   = run_var_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      neg_in       = neg_ff;
      ad_in        = ad_ff;
      prod_hi_in   = prod_hi_ff;
      prod_lo_in   = prod_lo_ff;
      div_rem_in   = div_rem_ff;
      div_quo_in   = div_quo_ff;
      div_den_in   = div_den_ff;
      mean_new_in  = mean_new_ff;
      t1_in        = t1_ff;
      var_new_in   = var_new_ff;
      sat_new_in   = sat_new_ff;
      rsp_in       = rsp_ff;

      // Register writes; unknown indexes drop silently
      if (csr_we) begin
         case (csr_index)
            rmv_pkg::CSR_INIT_MEAN:     init_mean_in = csr_wdata[MB-1:0];
            rmv_pkg::CSR_INIT_VARIANCE: init_var_in  = csr_wdata[VB-1:0];
            default: ;
         endcase
      end

      // Release the result word once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         rmv_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_data.mode) begin
                  // Restart: load initial values, then commit in ST_FINISH
                  mean_new_in = init_mean_ff;
                  var_new_in  = init_var_ff;
                  n_in        = COUNT_BITS'(1);
                  sat_new_in  = 1'b0;
                  state_in    = rmv_pkg::ST_FINISH;
               end else begin
                  // Sample: start |d| / n and the squaring of |d| together
                  n_in        = n_next;
                  neg_in      = d_ext[AB];
                  ad_in       = ad_ext[AB-1:0];
                  prod_hi_in  = '0;
                  prod_lo_in  = ad_ext[AB-1:0];
                  div_rem_in  = '0;
                  div_quo_in  = {{(DB - AB){1'b0}}, ad_ext[AB-1:0]};
                  div_den_in  = n_next;
                  step_in     = '0;
                  state_in    = rmv_pkg::ST_DIV_MEAN;
               end
            end
         end

         rmv_pkg::ST_DIV_MEAN, rmv_pkg::ST_DIV_VAR, rmv_pkg::ST_DIV_SQ: begin
            if (step_ff != STEP_BITS'(DB)) begin
               // Advance the divider one quotient bit
               div_rem_in = div_ge ? div_diff[COUNT_BITS-1:0] : div_shift[COUNT_BITS-1:0];
               div_quo_in = {div_quo_ff[DB-2:0], div_ge};
               step_in    = step_ff + STEP_BITS'(1);
               if (state_ff == rmv_pkg::ST_DIV_MEAN && step_ff < STEP_BITS'(AB)) begin
                  prod_hi_in = mul_sum[AB:1];
                  prod_lo_in = {mul_sum[0], prod_lo_ff[AB-1:1]};
               end
            end else begin
               step_in    = '0;
               div_rem_in = '0;
               if (state_ff == rmv_pkg::ST_DIV_MEAN) begin
                  // Hold the new mean; divide the variance by n - 1 next
                  mean_new_in = mean_sum[MB-1:0];
                  div_quo_in  = run_var_ff;
                  div_den_in  = n_ff - COUNT_BITS'(1);
                  state_in    = rmv_pkg::ST_DIV_VAR;
               end else if (state_ff == rmv_pkg::ST_DIV_VAR) begin
                  // var * (n-2) / (n-1), floored, is var - ceil(var / (n-1))
                  t1_in      = run_var_ff - div_quo_ff - VB'(div_rem_ff != '0);
                  // d^2 / (n * 2^16) is floor(d^2 / 2^16) / n
                  div_quo_in = {prod_hi_ff, prod_lo_ff[AB-1:rmv_pkg::FRAC_SHIFT]};
                  div_den_in = n_ff;
                  state_in   = rmv_pkg::ST_DIV_SQ;
               end else begin
                  var_new_in = var_sum[VB] ? {VB{1'b1}} : var_sum[VB-1:0];
                  sat_new_in = var_sum[VB];
                  state_in   = rmv_pkg::ST_FINISH;
               end
            end
         end

         rmv_pkg::ST_FINISH: begin
            // Commit the statistics once the output register is free
            if (commit) begin
               run_mean_in                = mean_new_ff;
               run_var_in                 = var_new_ff;
               count_in                   = n_ff;
               rsp_in.mean_out            = mean_new_ff;
               rsp_in.variance_out        = var_new_ff;
               rsp_in.count_out           = count_trim;
               rsp_in.variance_saturated  = sat_new_ff;
               rsp_valid_in               = 1'b1;
               state_in                   = rmv_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = rmv_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
